// ===== src/iso8601_timestamp_to_epoch_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp-to-epoch converter
// Each macro expands to one labeled concurrent assertion on i_clk, held off
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ISO8601_TIMESTAMP_TO_EPOCH_TOP_DEFINES_SVH
`define ISO8601_TIMESTAMP_TO_EPOCH_TOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define TS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define TS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/iso_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// iso_ts_pkg
// Shared types, character codes and arithmetic constants of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iso_ts_pkg;

    // Number of fraction digits kept; later digits are truncated.
    localparam int FRAC_DIGITS = 9;

    // Character positions within the fixed layout YYYY-MM-DD?HH:MM:SS.
    localparam logic [4:0] POS_DASH_A    = 5'd4;
    localparam logic [4:0] POS_DASH_B    = 5'd7;
    localparam logic [4:0] POS_SEP       = 5'd10;
    localparam logic [4:0] POS_COLON_A   = 5'd13;
    localparam logic [4:0] POS_COLON_B   = 5'd16;
    localparam logic [4:0] POS_YEAR_END  = 5'd3;
    localparam logic [4:0] POS_MONTH_END = 5'd6;
    localparam logic [4:0] POS_DAY_END   = 5'd9;
    localparam logic [4:0] POS_HOUR_END  = 5'd12;
    localparam logic [4:0] POS_MIN_END   = 5'd15;
    localparam logic [4:0] POS_FRAC_MARK = 5'd19;
    localparam logic [4:0] POS_SAT       = 5'd20;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Civil-days constants.
    localparam logic signed [31:0] ERA_YEARS     = 32'sd400;
    localparam logic signed [31:0] ERA_DAYS      = 32'sd146097;
    localparam logic signed [31:0] DAYS_PER_YEAR = 32'sd365;
    localparam logic signed [31:0] MONTH_SCALE   = 32'sd153;
    localparam logic signed [39:0] MONTH_BIAS    = 40'sd2;
    localparam logic signed [31:0] SECS_PER_DAY  = 32'sd86400;
    localparam logic signed [31:0] SECS_PER_HOUR = 32'sd3600;
    localparam logic signed [31:0] SECS_PER_MIN  = 32'sd60;
    localparam logic signed [31:0] ONE           = 32'sd1;
    localparam logic signed [39:0] EPOCH_DAYS    = 40'sd719468;
    // The epoch day offset is folded into the seconds scaling.
    localparam logic signed [39:0] EPOCH_OFFSET_SECS =
        -(EPOCH_DAYS * 40'(SECS_PER_DAY));

    // Reciprocal multipliers for division by constants. Each is exact over
    // the operand range that reaches it (years up to 10399, year-of-era up
    // to 399, month terms up to 1685).
    localparam int               DIV400_SHIFT = 24;
    localparam logic signed [31:0] RECIP_400  = 32'sd41944;
    localparam int               DIV100_SHIFT = 16;
    localparam logic signed [31:0] RECIP_100  = 32'sd656;
    localparam int               DIV5_SHIFT   = 16;
    localparam logic signed [31:0] RECIP_5    = 32'sd13108;

    // Parsed token fields, plus the field-limit check.
    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] accum;
        logic [3:0]  digits;
        logic        ok;
    } t_fields;

    // Status and result of the date unit.
    typedef struct packed {
        logic        busy;
        logic        done;
        logic        ok;
        logic [38:0] epoch;
        logic [29:0] nanos;
    } t_calc_out;

    typedef enum logic [3:0] {
        C_IDLE,
        C_FRAC,
        C_ERA,
        C_YOE,
        C_DOY,
        C_DIV5,
        C_C100,
        C_DOE,
        C_DAYS,
        C_SECS,
        C_HOUR,
        C_MIN,
        C_SEC,
        C_DONE
    } t_calc_state;

    // Power of ten used to scale kept fraction digits to nanoseconds.
    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] v;
        unique case (n)
            4'd0:    v = 30'd1;
            4'd1:    v = 30'd10;
            4'd2:    v = 30'd100;
            4'd3:    v = 30'd1000;
            4'd4:    v = 30'd10000;
            4'd5:    v = 30'd100000;
            4'd6:    v = 30'd1000000;
            4'd7:    v = 30'd10000000;
            4'd8:    v = 30'd100000000;
            4'd9:    v = 30'd1000000000;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/iso8601_timestamp_to_epoch_top.sv =====
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_top
// Converts a timestamp token, one character per transfer, into a valid flag,
// signed Unix epoch seconds and fraction nanoseconds.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  -------------------------------------
//  input    in         i_valid / o_stall    i_ch, i_last
//  result   out        o_valid / i_stall    o_valid_res, o_epoch_seconds,
//                                           o_frac_nanos
//
//  Characters are taken one per cycle while o_stall is low. After the transfer
//  that carries the last mark, the date unit runs its twelve multiply-add
//  steps (one shared multiplier, one step per cycle) and a hold step that loads
//  the result register once it is free; a rejected token skips to the hold step.
//  o_stall is high from the cycle after the last character until the result
//  has entered the output register. The next token's characters are taken
//  while that result still waits for the downstream side.
//  Reset is synchronous and active low and clears the parser and sequencer.
//
`timescale 1ns / 1ps
`default_nettype none

`include "iso8601_timestamp_to_epoch_top_defines.svh"

module iso8601_timestamp_to_epoch_top
    import iso_ts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [7:0]         i_ch,
    input  wire logic               i_last,
    output logic                    o_stall,
    output logic                    o_valid,
    output logic                    o_valid_res,
    output logic signed [38:0]      o_epoch_seconds,
    output logic [29:0]             o_frac_nanos,
    input  wire logic               i_stall
);

    t_fields   w_fields;
    t_calc_out w_calc;

    logic w_take;
    logic w_out_free;
    logic w_load;

    logic               r_out_valid, n_out_valid;
    logic               r_valid_res;
    logic signed [38:0] r_epoch;
    logic [29:0]        r_nanos;

    // A character transfer completes whenever the date unit is not running.
    assign o_stall    = w_calc.busy;
    assign w_take     = i_valid && !o_stall;

    // The output register can take a new result when empty or being emptied.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_load     = w_calc.done && w_out_free;

    iso_ts_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_ch     (i_ch),
        .i_clear  (w_load),
        .o_fields (w_fields)
    );

    iso_ts_calc u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_take && i_last),
        .i_fields   (w_fields),
        .i_out_free (w_out_free),
        .o_calc     (w_calc)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload; it only changes when a new result is loaded.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_valid_res <= w_calc.ok;
            r_epoch     <= $signed(w_calc.epoch);
            r_nanos     <= w_calc.nanos;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_valid_res     = r_valid_res;
    assign o_epoch_seconds = r_epoch;
    assign o_frac_nanos    = r_nanos;

    // A rejected token reports zero seconds and zero nanoseconds.
    `TS_ASSERT_IMPL(a_reject_zero, o_valid && !o_valid_res, o_epoch_seconds == 39'sd0 && o_frac_nanos == 30'd0, "rejected token with nonzero result")

    // The fraction never reaches a full second.
    `TS_ASSERT_IMPL(a_nanos_range, o_valid, o_frac_nanos < 30'd1000000000, "fraction out of range")

    // The last character of a token starts the date unit, which holds off input.
    `TS_ASSERT_NEXT(a_last_stalls, i_valid && !o_stall && i_last, o_stall, "no stall after last character")

endmodule

`default_nettype wire

// ===== src/iso_ts_parse.sv =====
// ----------------------------------------------------------------------------
// iso_ts_parse
// Character parser: checks the layout and collects the decimal fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iso_ts_parse
    import iso_ts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_clear,
    output t_fields         o_fields
);

    logic [4:0]  r_pos, n_pos;
    logic        r_err, n_err;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day, n_day;
    logic [6:0]  r_hour, n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;
    logic [29:0] r_accum, n_accum;
    logic [3:0]  r_digits, n_digits;
    logic        r_stopped, n_stopped;

    logic [7:0] w_digit;
    logic       w_is_dig;

    assign w_digit  = i_ch - CH_ZERO;
    assign w_is_dig = (w_digit <= 8'd9);

    always_comb begin
        n_pos     = r_pos;
        n_err     = r_err;
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_second  = r_second;
        n_accum   = r_accum;
        n_digits  = r_digits;
        n_stopped = r_stopped;
        if (i_clear) begin
            n_pos     = '0;
            n_err     = 1'b0;
            n_year    = '0;
            n_month   = '0;
            n_day     = '0;
            n_hour    = '0;
            n_minute  = '0;
            n_second  = '0;
            n_accum   = '0;
            n_digits  = '0;
            n_stopped = 1'b0;
        end else if (i_take) begin
            if (r_pos < POS_FRAC_MARK) begin
                unique case (r_pos)
                    POS_DASH_A, POS_DASH_B: begin
                        if (i_ch != CH_DASH) n_err = 1'b1;
                    end
                    POS_SEP: begin
                        if (i_ch != CH_T && i_ch != CH_SPACE) n_err = 1'b1;
                    end
                    POS_COLON_A, POS_COLON_B: begin
                        if (i_ch != CH_COLON) n_err = 1'b1;
                    end
                    default: begin
                        if (!w_is_dig) begin
                            n_err = 1'b1;
                        end else if (r_pos <= POS_YEAR_END) begin
                            n_year = 14'(r_year * 14'd10 + {10'd0, w_digit[3:0]});
                        end else if (r_pos <= POS_MONTH_END) begin
                            n_month = 7'(r_month * 7'd10 + {3'd0, w_digit[3:0]});
                        end else if (r_pos <= POS_DAY_END) begin
                            n_day = 7'(r_day * 7'd10 + {3'd0, w_digit[3:0]});
                        end else if (r_pos <= POS_HOUR_END) begin
                            n_hour = 7'(r_hour * 7'd10 + {3'd0, w_digit[3:0]});
                        end else if (r_pos <= POS_MIN_END) begin
                            n_minute = 7'(r_minute * 7'd10 + {3'd0, w_digit[3:0]});
                        end else begin
                            n_second = 7'(r_second * 7'd10 + {3'd0, w_digit[3:0]});
                        end
                    end
                endcase
            end else if (r_pos == POS_FRAC_MARK) begin
                if (i_ch != CH_DOT) n_stopped = 1'b1;
            end else if (!r_stopped) begin
                if (!w_is_dig) begin
                    n_stopped = 1'b1;
                end else if (r_digits < 4'(FRAC_DIGITS)) begin
                    n_accum  = 30'(r_accum * 30'd10 + {26'd0, w_digit[3:0]});
                    n_digits = r_digits + 4'd1;
                end
            end
            if (r_pos < POS_SAT) n_pos = r_pos + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_err     <= 1'b0;
            r_year    <= '0;
            r_month   <= '0;
            r_day     <= '0;
            r_hour    <= '0;
            r_minute  <= '0;
            r_second  <= '0;
            r_accum   <= '0;
            r_digits  <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_err     <= n_err;
            r_year    <= n_year;
            r_month   <= n_month;
            r_day     <= n_day;
            r_hour    <= n_hour;
            r_minute  <= n_minute;
            r_second  <= n_second;
            r_accum   <= n_accum;
            r_digits  <= n_digits;
            r_stopped <= n_stopped;
        end
    end

    always_comb begin
        o_fields.year   = r_year;
        o_fields.month  = r_month;
        o_fields.day    = r_day;
        o_fields.hour   = r_hour;
        o_fields.minute = r_minute;
        o_fields.second = r_second;
        o_fields.accum  = r_accum;
        o_fields.digits = r_digits;
        o_fields.ok     = !r_err && (r_pos >= POS_FRAC_MARK) &&
                          (r_month >= 7'd1) && (r_month <= 7'd12) &&
                          (r_day >= 7'd1) && (r_day <= 7'd31) &&
                          (r_hour <= 7'd23) && (r_minute <= 7'd59) &&
                          (r_second <= 7'd60);
    end

endmodule

`default_nettype wire

// ===== src/iso_ts_calc.sv =====
// ----------------------------------------------------------------------------
// iso_ts_calc
// Date unit: one shared multiply-add stepped by a sequencer turns the parsed
// fields into epoch seconds and nanoseconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iso_ts_calc
    import iso_ts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_fields i_fields,
    input  wire logic    i_out_free,
    output t_calc_out    o_calc
);

    t_calc_state r_state, n_state;

    logic signed [39:0] r_acc;
    logic               r_ok;
    logic [29:0]        r_nanos;
    logic signed [5:0]  r_era;
    logic [8:0]         r_yoe;
    logic [8:0]         r_doy;

    // Shared multiply-add: acc = a * b + c.
    logic signed [31:0] w_a, w_b;
    logic signed [39:0] w_c;
    logic signed [63:0] w_prod;
    logic signed [39:0] w_mac;

    logic [14:0] w_ypos;
    logic [3:0]  w_mp;
    logic [10:0] w_doe_c;
    logic [4:0]  w_era1;

    // Year shifted up by one era keeps the era division on nonnegative values.
    assign w_ypos = {1'b0, i_fields.year} + 15'(ERA_YEARS) -
                    ((i_fields.month <= 7'd2) ? 15'd1 : 15'd0);
    assign w_mp   = (i_fields.month > 7'd2) ? 4'(i_fields.month - 7'd3)
                                            : 4'(i_fields.month + 7'd9);
    assign w_era1 = r_acc[DIV400_SHIFT+4:DIV400_SHIFT];
    assign w_doe_c = 11'(r_yoe[8:2]) - 11'(r_acc[DIV100_SHIFT+1:DIV100_SHIFT]) +
                     11'(r_doy);

    assign w_prod = w_a * w_b;
    assign w_mac  = $signed(w_prod[39:0]) + w_c;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_FRAC;
            C_FRAC: n_state = i_fields.ok ? C_ERA : C_DONE;
            C_ERA:  n_state = C_YOE;
            C_YOE:  n_state = C_DOY;
            C_DOY:  n_state = C_DIV5;
            C_DIV5: n_state = C_C100;
            C_C100: n_state = C_DOE;
            C_DOE:  n_state = C_DAYS;
            C_DAYS: n_state = C_SECS;
            C_SECS: n_state = C_HOUR;
            C_HOUR: n_state = C_MIN;
            C_MIN:  n_state = C_SEC;
            C_SEC:  n_state = C_DONE;
            C_DONE: if (i_out_free) n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // Operand selection for the shared unit.
    always_comb begin
        w_a = '0;
        w_b = '0;
        w_c = '0;
        unique case (r_state)
            C_FRAC: begin
                w_a = {2'd0, i_fields.accum};
                w_b = {2'd0, pow10(4'(FRAC_DIGITS) - i_fields.digits +
                                   4'(9 - FRAC_DIGITS))};
            end
            C_ERA: begin
                w_a = {17'd0, w_ypos};
                w_b = RECIP_400;
            end
            C_YOE: begin
                w_a = {27'd0, w_era1};
                w_b = -ERA_YEARS;
                w_c = {25'd0, w_ypos};
            end
            C_DOY: begin
                w_a = {28'd0, w_mp};
                w_b = MONTH_SCALE;
                w_c = MONTH_BIAS;
            end
            C_DIV5: begin
                w_a = r_acc[31:0];
                w_b = RECIP_5;
            end
            C_C100: begin
                w_a = {23'd0, r_yoe};
                w_b = RECIP_100;
            end
            C_DOE: begin
                w_a = {23'd0, r_yoe};
                w_b = DAYS_PER_YEAR;
                w_c = {29'd0, w_doe_c};
            end
            C_DAYS: begin
                w_a = 32'(r_era);
                w_b = ERA_DAYS;
                w_c = r_acc;
            end
            C_SECS: begin
                w_a = r_acc[31:0];
                w_b = SECS_PER_DAY;
                w_c = EPOCH_OFFSET_SECS;
            end
            C_HOUR: begin
                w_a = {25'd0, i_fields.hour};
                w_b = SECS_PER_HOUR;
                w_c = r_acc;
            end
            C_MIN: begin
                w_a = {25'd0, i_fields.minute};
                w_b = SECS_PER_MIN;
                w_c = r_acc;
            end
            C_SEC: begin
                w_a = {25'd0, i_fields.second};
                w_b = ONE;
                w_c = r_acc;
            end
            default: begin
                w_a = '0;
                w_b = '0;
                w_c = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers; intermediate results are peeled off the
    // accumulator one step after they are formed.
    always_ff @(posedge i_clk) begin
        if (r_state != C_IDLE && r_state != C_DONE) r_acc <= w_mac;
        unique case (r_state)
            C_FRAC: r_ok <= i_fields.ok;
            C_ERA:  r_nanos <= r_acc[29:0];
            C_YOE:  r_era <= $signed({1'b0, w_era1}) - 6'sd1;
            C_DOY:  r_yoe <= r_acc[8:0];
            C_C100: r_doy <= r_acc[DIV5_SHIFT+8:DIV5_SHIFT] + 9'(i_fields.day) - 9'd1;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_calc.busy  = (r_state != C_IDLE);
        o_calc.done  = (r_state == C_DONE);
        o_calc.ok    = r_ok;
        o_calc.epoch = r_ok ? r_acc[38:0] : '0;
        o_calc.nanos = r_ok ? r_nanos : '0;
    end

endmodule

`default_nettype wire

// ===== dv/iso8601_timestamp_to_epoch_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_top_test
// Self-checking bench for the timestamp-to-epoch converter. Tokens go in one
// character per transfer, and an in-bench predictor works out the flag, epoch
// seconds and nanoseconds that each last-marked transfer must produce.
// ----------------------------------------------------------------------------

module iso8601_timestamp_to_epoch_top_test;
    import iso_ts_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_TICKS = 6;
    // Watchdog bound. The slowest correct run stays far below it.
    localparam int CYCLE_LIMIT = 1000000;
    // Length of the long downstream hold used to fill the converter.
    localparam int HOLD_CYCLES = 400;
    // Quiet time after the last result.
    localparam int DRAIN_TICKS = 40;

    // One result transfer, field by field.
    typedef struct packed {
        logic               ok;
        logic signed [38:0] secs;
        logic [29:0]        nanos;
    } t_epoch_result;

    // Every block input is known from time zero.
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_ch    = 8'h00;
    logic               i_last  = 1'b0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_valid_res;
    logic signed [38:0] o_epoch_seconds;
    logic [29:0]        o_frac_nanos;

    // Expected results, oldest first.
    t_epoch_result expected_epochs[$];
    // Characters of the token being sent.
    logic [7:0]    token_buf[$];

    // Predictor copy of the parser state.
    logic [4:0]  parse_pos    = '0;
    logic        parse_error  = 1'b0;
    logic [13:0] parse_year   = '0;
    logic [6:0]  parse_month  = '0;
    logic [6:0]  parse_day    = '0;
    logic [6:0]  parse_hour   = '0;
    logic [6:0]  parse_minute = '0;
    logic [6:0]  parse_second = '0;
    logic [29:0] frac_accum   = '0;
    logic [3:0]  frac_count   = '0;
    logic        frac_done    = 1'b0;

    // Run bookkeeping.
    bit idle_on         = 1'b1;
    int hold_cycles_req = 0;
    int rx_stall_left   = 0;
    int rx_ready_left   = 0;
    int fail_count      = 0;
    int chars_sent      = 0;
    int tokens_sent     = 0;
    int results_seen    = 0;
    int valid_seen      = 0;
    int cycle_count     = 0;

    iso8601_timestamp_to_epoch_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_ch            (i_ch),
        .i_last          (i_last),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .o_valid_res     (o_valid_res),
        .o_epoch_seconds (o_epoch_seconds),
        .o_frac_nanos    (o_frac_nanos),
        .i_stall         (i_stall)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gap length for either side: mostly none or short, now and then long.
    // With idling switched off it is always zero.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Appends one character to the token buffer.
    task automatic add_char(input logic [7:0] c);
        token_buf.insert(token_buf.size(), c);
    endtask

    // Advances the predictor by one accepted character. On the last mark it
    // converts the parsed fields with the era-based civil-days formula, queues
    // the expected result and clears the parser state.
    task automatic predict_epoch(input logic [7:0] c, input logic is_last);
        logic [7:0]    d;
        bit            dig;
        bit            fine;
        t_epoch_result res;
        longint        y;
        longint        era;
        longint        yoe;
        longint        m;
        longint        doy;
        longint        doe;
        longint        days;
        longint        total;
        longint        scale;
        d   = c - CH_ZERO;
        dig = (d <= 8'd9);
        if (parse_pos < POS_FRAC_MARK) begin
            case (parse_pos)
                POS_DASH_A, POS_DASH_B: begin
                    fine = (c == CH_DASH);
                end
                POS_SEP: begin
                    fine = (c == CH_T || c == CH_SPACE);
                end
                POS_COLON_A, POS_COLON_B: begin
                    fine = (c == CH_COLON);
                end
                default: begin
                    // A non-digit at a digit position leaves the field as it is.
                    fine = dig;
                    if (dig) begin
                        if (parse_pos <= POS_YEAR_END) begin
                            parse_year = 14'(parse_year * 10 + d);
                        end else if (parse_pos <= POS_MONTH_END) begin
                            parse_month = 7'(parse_month * 10 + d);
                        end else if (parse_pos <= POS_DAY_END) begin
                            parse_day = 7'(parse_day * 10 + d);
                        end else if (parse_pos <= POS_HOUR_END) begin
                            parse_hour = 7'(parse_hour * 10 + d);
                        end else if (parse_pos <= POS_MIN_END) begin
                            parse_minute = 7'(parse_minute * 10 + d);
                        end else begin
                            parse_second = 7'(parse_second * 10 + d);
                        end
                    end
                end
            endcase
            if (!fine) parse_error = 1'b1;
        end else if (parse_pos == POS_FRAC_MARK) begin
            if (c != CH_DOT) frac_done = 1'b1;
        end else if (!frac_done) begin
            // The digit run ends at the first non-digit; digits past the
            // kept count are dropped.
            if (!dig) begin
                frac_done = 1'b1;
            end else if (frac_count < FRAC_DIGITS) begin
                frac_accum = 30'(frac_accum * 10 + d);
                frac_count = frac_count + 1'b1;
            end
        end
        if (parse_pos < POS_SAT) parse_pos = parse_pos + 1'b1;

        if (is_last) begin
            fine = !parse_error && parse_pos >= POS_FRAC_MARK &&
                   parse_month >= 1 && parse_month <= 12 &&
                   parse_day >= 1 && parse_day <= 31 &&
                   parse_hour <= 23 && parse_minute <= 59 && parse_second <= 60;
            res = '0;
            if (fine) begin
                // Years start in March so that the leap day ends the year.
                y     = longint'(parse_year) - ((parse_month <= 2) ? 1 : 0);
                era   = ((y >= 0) ? y : y - 399) / 400;
                yoe   = y - era * 400;
                m     = longint'(parse_month) + ((parse_month > 2) ? -3 : 9);
                doy   = (153 * m + 2) / 5 + longint'(parse_day) - 1;
                doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
                days  = era * 146097 + doe - 719468;
                total = days * 86400 + longint'(parse_hour) * 3600 +
                        longint'(parse_minute) * 60 + longint'(parse_second);
                scale = 1;
                for (int i = frac_count; i < FRAC_DIGITS; i++) scale = scale * 10;
                res.ok    = 1'b1;
                res.secs  = total[38:0];
                res.nanos = 30'(longint'(frac_accum) * scale);
            end
            expected_epochs.insert(expected_epochs.size(), res);
            parse_pos    = '0;
            parse_error  = 1'b0;
            parse_year   = '0;
            parse_month  = '0;
            parse_day    = '0;
            parse_hour   = '0;
            parse_minute = '0;
            parse_second = '0;
            frac_accum   = '0;
            frac_count   = '0;
            frac_done    = 1'b0;
        end
    endtask

    // Offers one character and holds it until the converter takes it. On
    // return the transfer has happened at the current edge and i_valid is
    // still high, so a following character can go out back to back.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        i_last  <= is_last;
        do @(posedge i_clk); while (o_stall);
        predict_epoch(c, is_last);
        chars_sent++;
    endtask

    // Sends the whole token buffer, marking its final character.
    task automatic send_token();
        for (int i = 0; i < token_buf.size(); i++) begin
            send_char(token_buf[i], i == token_buf.size() - 1);
        end
        tokens_sent++;
    endtask

    task automatic load_text(input string s);
        token_buf.delete();
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic send_text(input string s);
        load_text(s);
        send_token();
    endtask

    // Builds a timestamp with random content. With wide_fields set, the
    // two-digit fields range over 00..99, so limits are crossed often. A
    // fraction of random length and trailing junk bytes may follow.
    task automatic build_timestamp(input bit wide_fields);
        int yr;
        int mo;
        int dy;
        int hr;
        int mi;
        int se;
        int nd;
        int r;
        r  = $urandom_range(0, 19);
        yr = (r == 0) ? 0 : (r == 1) ? 9999 : $urandom_range(0, 9999);
        mo = wide_fields ? $urandom_range(0, 99) : $urandom_range(1, 12);
        dy = wide_fields ? $urandom_range(0, 99) : $urandom_range(1, 31);
        hr = wide_fields ? $urandom_range(0, 99) : $urandom_range(0, 23);
        mi = wide_fields ? $urandom_range(0, 99) : $urandom_range(0, 59);
        se = wide_fields ? $urandom_range(0, 99) : $urandom_range(0, 60);
        load_text($sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", yr, mo, dy,
                            $urandom_range(0, 1) ? "T" : " ", hr, mi, se));
        if ($urandom_range(0, 2) != 0) begin
            add_char(CH_DOT);
            nd = $urandom_range(0, 12);
            repeat (nd) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) begin
            nd = $urandom_range(1, 4);
            repeat (nd) add_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Lowers i_valid and waits until every queued result has been checked.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_epochs.size() != 0) @(posedge i_clk);
    endtask

    // Well-formed layouts: both separators, the year extremes on both sides of
    // the leap day, the largest timestamp, a day past the month's end, and
    // the fraction forms (short, over-long, junk after it, bare dot, none).
    task automatic test_accepted_layouts();
        send_text("1970-01-01T00:00:00");
        send_text("0000-01-01T00:00:00");
        send_text("0000-03-01 00:00:00");
        send_text("9999-12-31T23:59:60.999999999");
        send_text("2000-02-29 12:34:56.5");
        send_text("2024-02-31T00:00:00");
        send_text("2021-06-15T08:30:00.1234567891234");
        send_text("2021-06-15T08:30:00.12Zjunk");
        send_text("2021-06-15T08:30:00.");
        send_text("2021-06-15T08:30:00Z0123");
    endtask

    // Rejected tokens: too short, each field just past its limit, a wrong
    // character at each kind of punctuation, a letter in a digit position,
    // and the raw byte extremes.
    task automatic test_rejected_layouts();
        send_text("2");
        send_text("2021-06-15T08:30:0");
        send_text("2021-00-15T08:30:00");
        send_text("2021-13-15T08:30:00");
        send_text("2021-06-00T08:30:00");
        send_text("2021-06-32T08:30:00");
        send_text("2021-06-15T24:30:00");
        send_text("2021-06-15T08:60:00");
        send_text("2021-06-15T08:30:61");
        send_text("2021-06-15X08:30:00");
        send_text("2021/06-15T08:30:00");
        send_text("2021-06-15T08-30:00");
        send_text("20a1-06-15T08:30:00");
        token_buf.delete();
        add_char(8'h00);
        add_char(8'hFF);
        send_token();
        load_text("2021-06-15T08:30:00.5");
        token_buf[0] = 8'hFF;
        send_token();
    endtask

    // The receiver holds off for a long stretch while the sender keeps going
    // with no gaps, so results pile up and the converter stalls its input.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        hold_cycles_req = HOLD_CYCLES;
        repeat (4) begin
            build_timestamp(1'b0);
            send_token();
        end
        idle_on = 1'b1;
    endtask

    // Random tokens: mostly well-formed timestamps, some broken ones
    // (a corrupted byte or a cut-short token) and some pure byte noise.
    task automatic test_random_tokens(input int n_chars, input bit with_idle);
        int first;
        int kind;
        int idx;
        int keep;
        int len;
        idle_on = with_idle;
        first = chars_sent;
        while (chars_sent - first < n_chars) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_timestamp(1'b0);
            end else if (kind < 88) begin
                build_timestamp($urandom_range(0, 1));
                if ($urandom_range(0, 1)) begin
                    idx = $urandom_range(0, token_buf.size() - 1);
                    token_buf[idx] = 8'($urandom_range(0, 255));
                end else begin
                    keep = $urandom_range(1, 18);
                    while (token_buf.size() > keep) void'(token_buf.pop_back());
                end
            end else begin
                token_buf.delete();
                len = $urandom_range(1, 24);
                repeat (len) add_char(8'($urandom_range(0, 255)));
            end
            send_token();
        end
        idle_on = 1'b1;
    endtask

    // Compares one accepted result with the oldest expectation.
    task automatic check_epoch_result();
        t_epoch_result got;
        t_epoch_result want;
        got.ok    = o_valid_res;
        got.secs  = o_epoch_seconds;
        got.nanos = o_frac_nanos;
        if (expected_epochs.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("ERROR: unexpected result ok=%0b secs=%0d nanos=%0d",
                         got.ok, got.secs, got.nanos);
            end
        end else begin
            want = expected_epochs.pop_front();
            results_seen++;
            if (want.ok) valid_seen++;
            if (got.ok !== want.ok || got.secs !== want.secs ||
                got.nanos !== want.nanos) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("ERROR: result %0d expected %0b/%0d/%0d got %0b/%0d/%0d",
                             results_seen, want.ok, want.secs, want.nanos,
                             got.ok, got.secs, got.nanos);
                end
            end
        end
    endtask

    // Receiver: checks each result transfer, then picks the stall for the
    // next cycle. A requested long hold overrides the random pattern and is
    // counted down here, independent of what the sender is doing.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_epoch_result();
            if (hold_cycles_req > 0) begin
                rx_stall_left   = hold_cycles_req;
                hold_cycles_req = 0;
            end else if (rx_stall_left == 0 && rx_ready_left == 0) begin
                rx_stall_left = pick_gap();
                rx_ready_left = $urandom_range(1, 6);
            end
            if (rx_stall_left > 0) begin
                i_stall <= 1'b1;
                rx_stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (rx_ready_left > 0) rx_ready_left--;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_epochs.size());
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence. Reset is applied once; the sender pauses until all
    // results are in between the directed, pressure and random phases.
    initial begin
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_accepted_layouts();
        test_rejected_layouts();
        wait_for_results();
        test_output_backpressure();
        wait_for_results();
        test_random_tokens(150, 1'b1);
        test_random_tokens(60, 1'b0);
        wait_for_results();
        test_random_tokens(100, 1'b1);
        wait_for_results();
        // Any stray result after the last expected one shows up here.
        repeat (DRAIN_TICKS) @(posedge i_clk);

        $display("Sent %0d tokens in %0d characters; checked %0d results, %0d valid.",
                 tokens_sent, chars_sent, results_seen, valid_seen);
        $display("Included directed limit cases, a %0d-cycle output hold and random gaps.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
